>>> sv/rdi_pkg.sv
// Shared constants and the CORDIC arctangent table for the ray/disk intersector.
`timescale 1ns / 1ps
`default_nettype none

package rdi_pkg;

  // Default configuration of the datapath
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Width of a distance (hit_t, ray_max_t) and of a radius
  localparam int T_W = 31;

  // Two pi in unsigned Q3.28
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

  // Register indexes on the configuration port (byte address / 4)
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FLIP   = 2'd2;

  // atan(2^-i) as a fraction of a full turn, 32-bit phase
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> sv/rdi_div.sv
// Pipelined restoring divider, one quotient bit per register stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none

module rdi_div #(
  parameter int NW = 48,  // numerator width
  parameter int DW = 32,  // divisor width
  parameter int QW = 31,  // quotient width; requires num >> QW below den
  parameter int SW = 1    // sideband width
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [QW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);

  localparam int AW = DW + QW;

  // Partial remainder in the upper bits, numerator bits and quotient in the lower
  logic          vld  [QW];
  logic [AW-1:0] acc  [QW];
  logic [DW-1:0] den  [QW];
  logic [SW-1:0] side [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic          vld_prev;
    logic [AW-1:0] acc_prev;
    logic [DW-1:0] den_prev;
    logic [SW-1:0] side_prev;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (g == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign acc_prev  = {DW'(in_num[NW-1:QW]), in_num[QW-1:0]};
      assign den_prev  = in_den;
      assign side_prev = in_side;
    end else begin : g_rest
      assign vld_prev  = vld[g-1];
      assign acc_prev  = acc[g-1];
      assign den_prev  = den[g-1];
      assign side_prev = side[g-1];
    end

    // Try to subtract the divisor from the shifted remainder
    assign trial = acc_prev[AW-1:QW-1];
    assign diff  = trial - {1'b0, den_prev};
    assign ge    = trial >= {1'b0, den_prev};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[g]  <= ge ? {diff[DW-1:0], acc_prev[QW-2:0], 1'b1}
                      : {trial[DW-1:0], acc_prev[QW-2:0], 1'b0};
        den[g]  <= den_prev;
        side[g] <= side_prev;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = acc[QW-1][QW-1:0];
  assign out_side  = side[QW-1];

endmodule

`default_nettype wire

>>> sv/rdi_isqrt.sv
// Pipelined integer square root, one root bit per register stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none

module rdi_isqrt #(
  parameter int RW = 31,  // root width; radicand is twice as wide
  parameter int SW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [2*RW-1:0] in_n,
  input  wire logic [SW-1:0]   in_side,
  output logic                 out_valid,
  output logic [RW-1:0]        out_root,
  output logic [SW-1:0]        out_side
);

  logic            vld  [RW];
  logic [RW+1:0]   rem  [RW];
  logic [RW-1:0]   root [RW];
  logic [2*RW-1:0] nrem [RW];
  logic [SW-1:0]   side [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic            vld_prev;
    logic [RW+1:0]   rem_prev;
    logic [RW-1:0]   root_prev;
    logic [2*RW-1:0] nrem_prev;
    logic [SW-1:0]   side_prev;
    logic [RW+3:0]   cur;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;

    if (g == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign nrem_prev = in_n;
      assign side_prev = in_side;
    end else begin : g_rest
      assign vld_prev  = vld[g-1];
      assign rem_prev  = rem[g-1];
      assign root_prev = root[g-1];
      assign nrem_prev = nrem[g-1];
      assign side_prev = side[g-1];
    end

    // Bring down the next bit pair and test 4*root+1
    assign cur   = {rem_prev, nrem_prev[2*RW-1:2*RW-2]};
    assign trial = {2'b00, root_prev, 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g]  <= ge ? diff[RW+1:0] : cur[RW+1:0];
        root[g] <= {root_prev[RW-2:0], ge};
        nrem[g] <= {nrem_prev[2*RW-3:0], 2'b00};
        side[g] <= side_prev;
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_root  = root[RW-1];
  assign out_side  = side[RW-1];

endmodule

`default_nettype wire

>>> sv/rdi_cordic.sv
// Pipelined CORDIC vectoring: angle of (x, y) as a 32-bit turn phase, with sideband.
`timescale 1ns / 1ps
`default_nettype none

module rdi_cordic #(
  parameter int STEPS = rdi_pkg::CORDIC_STEPS_DEF,
  parameter int SW    = 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic [SW-1:0]      in_side,
  output logic                    out_valid,
  output logic [31:0]             out_phase,
  output logic [SW-1:0]           out_side
);

  // Room for the negated input and the CORDIC gain
  localparam int CW = 35;

  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;
  logic [31:0]          ph0;

  // Fold the left half plane onto the right half, half a turn apart
  always_comb begin
    if (in_x[31]) begin
      x0  = -CW'(in_x);
      y0  = -CW'(in_y);
      ph0 = 32'h8000_0000;
    end else begin
      x0  = CW'(in_x);
      y0  = CW'(in_y);
      ph0 = '0;
    end
  end

  logic                 vld  [STEPS];
  logic signed [CW-1:0] xr   [STEPS];
  logic signed [CW-1:0] yr   [STEPS];
  logic [31:0]          ph   [STEPS];
  logic [SW-1:0]        side [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    logic                 vld_prev;
    logic signed [CW-1:0] x_prev;
    logic signed [CW-1:0] y_prev;
    logic [31:0]          ph_prev;
    logic [SW-1:0]        side_prev;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic                 pos;

    if (g == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign x_prev    = x0;
      assign y_prev    = y0;
      assign ph_prev   = ph0;
      assign side_prev = in_side;
    end else begin : g_rest
      assign vld_prev  = vld[g-1];
      assign x_prev    = xr[g-1];
      assign y_prev    = yr[g-1];
      assign ph_prev   = ph[g-1];
      assign side_prev = side[g-1];
    end

    assign xs  = x_prev >>> g;
    assign ys  = y_prev >>> g;
    assign pos = !y_prev[CW-1] && (y_prev != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld_prev;
      end
    end

    // Rotate toward the x axis and accumulate the angle
    always_ff @(posedge clk) begin
      if (en) begin
        if (pos) begin
          xr[g] <= x_prev + ys;
          yr[g] <= y_prev - xs;
          ph[g] <= ph_prev + rdi_pkg::atan_turn(g);
        end else begin
          xr[g] <= x_prev - ys;
          yr[g] <= y_prev + xs;
          ph[g] <= ph_prev - rdi_pkg::atan_turn(g);
        end
        side[g] <= side_prev;
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_phase = ph[STEPS-1];
  assign out_side  = side[STEPS-1];

endmodule

`default_nettype wire

>>> sv/ray_disk_intersect.sv
// Top level of the pipelined ray/disk intersector with its configuration registers.
//
//   Channel  Dir  Handshake              Carries
//   s_*      in   s_tvalid / s_tready    one ray per transaction (s_tdata)
//   m_*      out  m_tvalid / m_tready    one result per transaction (m_tdata, m_tuser)
//   p*       in   psel / penable         disk_radius, disk_height, flip_normal
//
// One ray enters per cycle unless a stall on m_tready holds it. A ray passes the
// distance divider, the square root, the dp/dv and v dividers, the CORDIC angle
// unit and eight single stages around them.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
// A stall on m_tready freezes every stage at once; s_tready follows it.
`timescale 1ns / 1ps
`default_nettype none

module ray_disk_intersect #(
  parameter int FRAC_BITS    = rdi_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = rdi_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Ray stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // ox[31:0] oy[63:32] oz[95:64] dx[127:96] dy[159:128] dz[191:160]
  // max_t[222:192], zero pad [223]
  input  wire logic [223:0] s_tdata,
  // Result stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // hit_t[30:0] hit_x[62:31] hit_y[94:63] tex_u[111:95] tex_v[128:112]
  // dpdu_x[160:129] dpdu_y[192:161] dpdv_x[224:193] dpdv_y[256:225]
  // normal_down[257], zero pad [263:258]
  output logic [263:0]      m_tdata,
  // hit[0]
  output logic              m_tuser,
  // Configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int TW     = rdi_pkg::T_W;
  localparam int NUMW   = 32 + FRAC_BITS;
  localparam int PW     = 2 * TW;
  localparam int V_FRAC = 16;
  localparam int VNW    = TW + V_FRAC;

  typedef struct packed {
    logic [30:0]        max_t;
    logic signed [31:0] dz;
    logic signed [31:0] dy;
    logic signed [31:0] dx;
    logic signed [31:0] oz;
    logic signed [31:0] oy;
    logic signed [31:0] ox;
  } ray_t;

  typedef struct packed {
    logic               miss;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [TW-1:0]      max_t;
  } tside_t;

  typedef struct packed {
    logic               miss;
    logic [TW-1:0]      t;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        dux;
    logic [31:0]        duy;
    logic [PW-1:0]      ax;
    logic [PW-1:0]      ay;
    logic [PW-1:0]      d2;
  } cside_t;

  typedef struct packed {
    logic               miss;
    logic [TW-1:0]      t;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        dux;
    logic [31:0]        duy;
    logic [PW-1:0]      ax;
    logic [PW-1:0]      ay;
    logic [31:0]        phase;
  } qside_t;

  typedef struct packed {
    logic               miss;
    logic [TW-1:0]      t;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        u;
    logic               r_zero;
  } xside_t;

  typedef struct packed {
    logic [31:0] dux;
    logic [31:0] duy;
  } yside_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic        normal_down;
    logic [31:0] dpdv_y;
    logic [31:0] dpdv_x;
    logic [31:0] dpdu_y;
    logic [31:0] dpdu_x;
    logic [16:0] tex_v;
    logic [16:0] tex_u;
    logic [31:0] hit_y;
    logic [31:0] hit_x;
    logic [30:0] hit_t;
  } out_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [30:0] disk_radius;
  logic [31:0] disk_height;
  logic        flip_normal;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Write a register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_radius <= 31'd65536;
      disk_height <= '0;
      flip_normal <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rdi_pkg::REG_RADIUS: disk_radius <= pwdata[30:0];
        rdi_pkg::REG_HEIGHT: disk_height <= pwdata;
        rdi_pkg::REG_FLIP:   flip_normal <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      rdi_pkg::REG_RADIUS: prdata = {1'b0, disk_radius};
      rdi_pkg::REG_HEIGHT: prdata = disk_height;
      rdi_pkg::REG_FLIP:   prdata = {31'b0, flip_normal};
      default:             prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- flow
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ------------------------------------------------- stage A: plane offset
  ray_t               ray;
  logic signed [32:0] dnum;
  logic [31:0]        anum;
  logic [31:0]        adz;
  logic               pre_miss;

  assign ray      = ray_t'(s_tdata[222:0]);
  assign dnum     = {disk_height[31], disk_height} - {ray.oz[31], ray.oz};
  assign anum     = dnum[32] ? 32'(-dnum) : dnum[31:0];
  assign adz      = ray.dz[31] ? 32'(-ray.dz) : 32'(ray.dz);
  assign pre_miss = (ray.dz == '0) || (dnum == '0) || (dnum[32] != ray.dz[31]);

  logic            a_vld;
  logic [NUMW-1:0] a_num;
  logic [31:0]     a_den;
  tside_t          a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_num        <= {anum, FRAC_BITS'(0)};
      a_den        <= adz;
      a_side.miss  <= pre_miss;
      a_side.ox    <= ray.ox;
      a_side.oy    <= ray.oy;
      a_side.dx    <= ray.dx;
      a_side.dy    <= ray.dy;
      a_side.max_t <= ray.max_t;
    end
  end

  // ----------------------------------- stage B: drop quotients past 31 bits
  logic            b_vld;
  logic [NUMW-1:0] b_num;
  logic [31:0]     b_den;
  tside_t          b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_num        <= a_num;
      b_den        <= a_den;
      b_side.miss  <= a_side.miss || (32'(a_num[NUMW-1:TW]) >= a_den);
      b_side.ox    <= a_side.ox;
      b_side.oy    <= a_side.oy;
      b_side.dx    <= a_side.dx;
      b_side.dy    <= a_side.dy;
      b_side.max_t <= a_side.max_t;
    end
  end

  // ----------------------------------------------- distance divider
  logic          dt_vld;
  logic [TW-1:0] dt_q;
  tside_t        dt_side;

  rdi_div #(
    .NW (NUMW),
    .DW (32),
    .QW (TW),
    .SW ($bits(tside_t))
  ) u_div_t (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_vld),
    .in_num    (b_num),
    .in_den    (b_den),
    .in_side   (b_side),
    .out_valid (dt_vld),
    .out_quo   (dt_q),
    .out_side  (dt_side)
  );

  // ------------------------------------- stage C: range check, d * t
  logic               c_vld;
  logic               c_miss;
  logic [TW-1:0]      c_t;
  logic signed [31:0] c_ox;
  logic signed [31:0] c_oy;
  logic signed [63:0] c_prx;
  logic signed [63:0] c_pry;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= dt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_miss <= dt_side.miss || (dt_q == '0) || (dt_q >= dt_side.max_t);
      c_t    <= dt_q;
      c_ox   <= dt_side.ox;
      c_oy   <= dt_side.oy;
      c_prx  <= 64'(dt_side.dx) * $signed({33'b0, dt_q});
      c_pry  <= 64'(dt_side.dy) * $signed({33'b0, dt_q});
    end
  end

  // ---------------------------------------------- stage D: hit point
  logic               d_vld;
  logic               d_miss;
  logic [TW-1:0]      d_t;
  logic signed [63:0] d_px;
  logic signed [63:0] d_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_miss <= c_miss;
      d_t    <= c_t;
      d_px   <= 64'(c_ox) + (c_prx >>> FRAC_BITS);
      d_py   <= 64'(c_oy) + (c_pry >>> FRAC_BITS);
    end
  end

  // ------------------------------------------ stage E: bounding square
  logic signed [63:0] rad64;
  logic               e_vld;
  logic               e_miss;
  logic [TW-1:0]      e_t;
  logic signed [31:0] e_px;
  logic signed [31:0] e_py;

  assign rad64 = $signed({33'b0, disk_radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_miss <= d_miss || (d_px > rad64) || (d_px < -rad64) ||
                (d_py > rad64) || (d_py < -rad64);
      e_t    <= d_t;
      e_px   <= d_px[31:0];
      e_py   <= d_py[31:0];
    end
  end

  // ------------------------------------------- stage F: products
  logic [31:0]        abs_px;
  logic [31:0]        abs_py;
  logic               f_vld;
  logic               f_miss;
  logic [TW-1:0]      f_t;
  logic signed [31:0] f_px;
  logic signed [31:0] f_py;
  logic [63:0]        f_pxx;
  logic [63:0]        f_pyy;
  logic [PW-1:0]      f_rr;
  logic signed [63:0] f_pxc;
  logic signed [63:0] f_pyc;
  logic [PW-1:0]      f_ax;
  logic [PW-1:0]      f_ay;

  assign abs_px = e_px[31] ? 32'(-e_px) : 32'(e_px);
  assign abs_py = e_py[31] ? 32'(-e_py) : 32'(e_py);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_miss <= e_miss;
      f_t    <= e_t;
      f_px   <= e_px;
      f_py   <= e_py;
      f_pxx  <= 64'(e_px) * 64'(e_px);
      f_pyy  <= 64'(e_py) * 64'(e_py);
      f_rr   <= PW'(disk_radius) * PW'(disk_radius);
      f_pxc  <= 64'(e_px) * $signed({33'b0, rdi_pkg::TWO_PI_Q28});
      f_pyc  <= 64'(e_py) * $signed({33'b0, rdi_pkg::TWO_PI_Q28});
      f_ax   <= PW'(abs_px[TW-1:0]) * PW'(disk_radius);
      f_ay   <= PW'(abs_py[TW-1:0]) * PW'(disk_radius);
    end
  end

  // ------------------------------- stage G: disk test, dp/du rounding
  logic [63:0]        d2sum;
  logic signed [63:0] dux_full;
  logic signed [63:0] duy_full;
  logic               g_vld;
  cside_t             g_side;

  assign d2sum    = f_pxx + f_pyy;
  assign dux_full = (64'sd134217728 - f_pyc) >>> 28;
  assign duy_full = (f_pxc + 64'sd134217728) >>> 28;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (en) begin
      g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_side.miss <= f_miss || (d2sum > 64'(f_rr));
      g_side.t    <= f_t;
      g_side.px   <= f_px;
      g_side.py   <= f_py;
      g_side.dux  <= sat32(dux_full);
      g_side.duy  <= sat32(duy_full);
      g_side.ax   <= f_ax;
      g_side.ay   <= f_ay;
      g_side.d2   <= d2sum[PW-1:0];
    end
  end

  // ------------------------------------------------- angle
  logic        co_vld;
  logic [31:0] co_phase;
  cside_t      co_side;
  qside_t      q_in;

  rdi_cordic #(
    .STEPS (CORDIC_STEPS),
    .SW    ($bits(cside_t))
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_vld),
    .in_x      (g_side.px),
    .in_y      (g_side.py),
    .in_side   (g_side),
    .out_valid (co_vld),
    .out_phase (co_phase),
    .out_side  (co_side)
  );

  always_comb begin
    q_in.miss  = co_side.miss;
    q_in.t     = co_side.t;
    q_in.px    = co_side.px;
    q_in.py    = co_side.py;
    q_in.dux   = co_side.dux;
    q_in.duy   = co_side.duy;
    q_in.ax    = co_side.ax;
    q_in.ay    = co_side.ay;
    q_in.phase = co_phase;
  end

  // ------------------------------------------------- hit radius
  logic          sq_vld;
  logic [TW-1:0] sq_root;
  qside_t        sq_side;

  rdi_isqrt #(
    .RW (TW),
    .SW ($bits(qside_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (co_vld),
    .in_n      (co_side.d2),
    .in_side   (q_in),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ------------------------------------- u, and inputs of the last dividers
  logic [31:0]    ph_round;
  logic [VNW-1:0] v_num;
  xside_t         x_in;
  yside_t         y_in;
  logic           v_in;

  assign ph_round = sq_side.phase + 32'h0000_8000;
  assign v_num    = {disk_radius - sq_root, V_FRAC'(0)};
  assign v_in     = (disk_radius == '0);

  always_comb begin
    x_in.miss   = sq_side.miss;
    x_in.t      = sq_side.t;
    x_in.px     = sq_side.px;
    x_in.py     = sq_side.py;
    x_in.r_zero = (sq_root == '0);
    x_in.u      = (sq_root == '0) ? 16'h0000 : ph_round[31:16];
    y_in.dux    = sq_side.dux;
    y_in.duy    = sq_side.duy;
  end

  logic          vx_vld;
  logic [TW-1:0] vx_q;
  xside_t        vx_side;
  logic          vy_vld;
  logic [TW-1:0] vy_q;
  yside_t        vy_side;
  logic          vv_vld;
  logic [TW-1:0] vv_q;
  logic          vv_rzero;

  rdi_div #(
    .NW (PW),
    .DW (TW),
    .QW (TW),
    .SW ($bits(xside_t))
  ) u_div_vx (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_vld),
    .in_num    (sq_side.ax),
    .in_den    (sq_root),
    .in_side   (x_in),
    .out_valid (vx_vld),
    .out_quo   (vx_q),
    .out_side  (vx_side)
  );

  rdi_div #(
    .NW (PW),
    .DW (TW),
    .QW (TW),
    .SW ($bits(yside_t))
  ) u_div_vy (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_vld),
    .in_num    (sq_side.ay),
    .in_den    (sq_root),
    .in_side   (y_in),
    .out_valid (vy_vld),
    .out_quo   (vy_q),
    .out_side  (vy_side)
  );

  rdi_div #(
    .NW (VNW),
    .DW (TW),
    .QW (TW),
    .SW (1)
  ) u_div_v (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_vld),
    .in_num    (v_num),
    .in_den    (disk_radius),
    .in_side   (v_in),
    .out_valid (vv_vld),
    .out_quo   (vv_q),
    .out_side  (vv_rzero)
  );

  // ------------------------------------------------- result register
  out_t res;
  out_t m_res;
  logic m_hit;

  always_comb begin
    res = '0;
    if (!vx_side.miss) begin
      res.hit_t       = vx_side.t;
      res.hit_x       = vx_side.px;
      res.hit_y       = vx_side.py;
      res.tex_u       = {1'b0, vx_side.u};
      res.tex_v       = vv_rzero ? 17'd0 : vv_q[16:0];
      res.dpdu_x      = vy_side.dux;
      res.dpdu_y      = vy_side.duy;
      if (!vx_side.r_zero) begin
        res.dpdv_x = vx_side.px[31] ? {1'b0, vx_q} : -{1'b0, vx_q};
        res.dpdv_y = vx_side.py[31] ? {1'b0, vy_q} : -{1'b0, vy_q};
      end
      res.normal_down = flip_normal;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vx_vld && vy_vld && vv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_res <= res;
      m_hit <= !vx_side.miss;
    end
  end

  assign m_tdata = m_res;
  assign m_tuser = m_hit;

endmodule

`default_nettype wire

>>> tb/sv/tb_ray_disk_intersect.sv
// Self-checking testbench for the ray/disk intersector: random and directed rays, APB setup.
`timescale 1ns / 1ps

module tb_ray_disk_intersect;
  import rdi_pkg::*;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
    logic [30:0]        max_t;
  } ray_t;

  typedef struct {
    logic        hit;
    logic [30:0] t;
    logic [31:0] x, y;
    logic [16:0] u, v;
    logic [31:0] dux, duy, dvx, dvy;
    logic        nd;
  } disk_hit_t;

  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 130;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [223:0]  s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [263:0]  m_tdata;
  logic          m_tuser;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  // Disk setup as the predictor sees it
  logic [30:0]        cfg_radius = 31'd65536;
  logic signed [31:0] cfg_height = '0;
  logic               cfg_flip = 1'b0;

  ray_t      ray_q[$];
  disk_hit_t hit_q[$];
  ray_t      cur_ray;
  int        src_idle = 0;
  int        snk_idle = 0;
  int        hold_ask = 0;
  int        hold_done = 0;
  int        hold_left = 0;
  int        stall_cnt = 0;
  int        errors = 0;

  ray_disk_intersect dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Integer square root, floor
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Angle of (x, y) as a 32-bit turn phase by vectoring rotations
  function automatic logic [31:0] turn_phase(longint x, longint y);
    logic [31:0] ph;
    longint      xs, ys;
    ph = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ph = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        ph = ph + atan_turn(i);
      end else begin
        x = x - ys;
        y = y + xs;
        ph = ph - atan_turn(i);
      end
    end
    return ph;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Expected intersection of one ray with the current disk
  function automatic disk_hit_t predict_hit(ray_t r);
    disk_hit_t       res;
    longint          ox, oy, oz, dx, dy, dz, num, t, px, py, dvx, dvy, dux, duy;
    longint unsigned rad, d2, rr, mag, v;
    logic [32:0]     ph;
    res = '{default: '0};
    ox = r.ox; oy = r.oy; oz = r.oz;
    dx = r.dx; dy = r.dy; dz = r.dz;
    rad = cfg_radius;
    dvx = 0;
    dvy = 0;
    if (dz == 0) return res;
    num = longint'(cfg_height) - oz;
    if (num == 0 || ((num < 0) != (dz < 0))) return res;
    t = ((num < 0 ? -num : num) << FRAC_BITS_DEF) / (dz < 0 ? -dz : dz);
    if (t == 0 || t >= longint'(r.max_t)) return res;
    px = ox + ((dx * t) >>> FRAC_BITS_DEF);
    py = oy + ((dy * t) >>> FRAC_BITS_DEF);
    if (px > longint'(rad) || -px > longint'(rad) ||
        py > longint'(rad) || -py > longint'(rad)) return res;
    d2 = px * px + py * py;
    if (d2 > rad * rad) return res;
    rr = isqrt(d2);
    if (rr == 0) begin
      ph = '0;
    end else begin
      ph = {1'b0, turn_phase(px, py)} + 33'd32768;
      mag = longint'(px < 0 ? -px : px) * rad / rr;
      dvx = px < 0 ? longint'(mag) : -longint'(mag);
      mag = longint'(py < 0 ? -py : py) * rad / rr;
      dvy = py < 0 ? longint'(mag) : -longint'(mag);
    end
    v = (rad == 0) ? 0 : ((rad - rr) << 16) / rad;
    dux = sat32((-py * longint'(TWO_PI_Q28) + (64'sd1 << 27)) >>> 28);
    duy = sat32((px * longint'(TWO_PI_Q28) + (64'sd1 << 27)) >>> 28);
    res.hit = 1'b1;
    res.t   = t[30:0];
    res.x   = px[31:0];
    res.y   = py[31:0];
    res.u   = {1'b0, ph[31:16]};
    res.v   = v[16:0];
    res.dux = dux[31:0];
    res.duy = duy[31:0];
    res.dvx = dvx[31:0];
    res.dvy = dvy[31:0];
    res.nd  = cfg_flip;
    return res;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
    r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
    r.max_t = $urandom;
    return r;
  endfunction

  // Ray aimed at a point near the disk, length at or past the hit distance or fully random
  function automatic ray_t aimed_ray();
    ray_t   r;
    longint rad, tx, ty, t, dz, dx, dy, oz, ox, oy, mt;
    rad = cfg_radius;
    tx = longint'({$urandom}) % (2 * rad + 1) - rad;
    ty = (longint'({$urandom}) % (2 * rad + 1) - rad) / 2;
    t = $urandom_range(1 << 20, 1);
    dz = $urandom_range(1 << 20, 1);
    if ($urandom_range(1)) dz = -dz;
    dx = longint'($urandom_range(1 << 19, 0)) - (1 << 18);
    dy = longint'($urandom_range(1 << 19, 0)) - (1 << 18);
    oz = longint'(cfg_height) - ((dz * t) >>> 16);
    ox = tx - ((dx * t) >>> 16);
    oy = ty - ((dy * t) >>> 16);
    if (oz > 64'sd2147483647 || oz < -64'sd2147483648 ||
        ox > 64'sd2147483647 || ox < -64'sd2147483648 ||
        oy > 64'sd2147483647 || oy < -64'sd2147483648) return noise_ray();
    case ($urandom_range(3))
      0, 1: mt = t + 1 + $urandom_range(1 << 16);
      2: mt = t;
      default: mt = $urandom_range(32'h7FFFFFFF);
    endcase
    if (mt > 64'sd2147483647) mt = 64'sd2147483647;
    r.ox = ox[31:0]; r.oy = oy[31:0]; r.oz = oz[31:0];
    r.dx = dx[31:0]; r.dy = dy[31:0]; r.dz = dz[31:0];
    r.max_t = mt[30:0];
    return r;
  endfunction

  task automatic add_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                         logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                         logic [30:0] mt);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz;
    r.dx = dx; r.dy = dy; r.dz = dz;
    r.max_t = mt;
    ray_q.push_back(r);
  endtask

  // APB write with a setup and an access phase; the register takes the value at the access edge
  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RADIUS: cfg_radius = data[30:0];
      REG_HEIGHT: cfg_height = data;
      default: cfg_flip = data[0];
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Drive rays: hold an offered transaction until taken, else offer the next
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) hit_q.push_back(predict_hit(cur_ray));
      if (s_tvalid && !s_tready) begin
        // hold
      end else if (ray_q.size() > 0 && $urandom_range(99) >= src_idle) begin
        cur_ray = ray_q.pop_front();
        s_tdata <= {1'b0, cur_ray.max_t, cur_ray.dz, cur_ray.dy, cur_ray.dx,
                    cur_ray.oz, cur_ray.oy, cur_ray.ox};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Check results and drive backpressure, with a long hold-off on request
  always @(posedge clk) begin
    disk_hit_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (hit_q.size() == 0) begin
          $error("result transaction with no ray outstanding");
          errors++;
        end else begin
          e = hit_q.pop_front();
          check_field("hit", e.hit, m_tuser);
          check_field("hit_t", e.t, m_tdata[30:0]);
          check_field("hit_x", e.x, m_tdata[62:31]);
          check_field("hit_y", e.y, m_tdata[94:63]);
          check_field("tex_u", e.u, m_tdata[111:95]);
          check_field("tex_v", e.v, m_tdata[128:112]);
          check_field("dpdu_x", e.dux, m_tdata[160:129]);
          check_field("dpdu_y", e.duy, m_tdata[192:161]);
          check_field("dpdv_x", e.dvx, m_tdata[224:193]);
          check_field("dpdv_y", e.dvy, m_tdata[256:225]);
          check_field("normal_down", e.nd, m_tdata[257]);
        end
      end
      if (hold_ask != hold_done) begin
        hold_done = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // Watchdog: end the run when work is pending and nothing moves
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (ray_q.size() == 0 && !s_tvalid && hit_q.size() == 0)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("[ray_disk_intersect] ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic wait_drained();
    while (ray_q.size() != 0 || s_tvalid || hit_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          apb_write(REG_RADIUS, 32'd10 << 16);
          apb_write(REG_HEIGHT, 32'd3 << 16);
          apb_write(REG_FLIP, 32'd1);
        end
        2: begin
          apb_write(REG_RADIUS, 32'd0);
          apb_write(REG_HEIGHT, 32'h80000000);
          apb_write(REG_FLIP, 32'd0);
        end
        3: begin
          apb_write(REG_RADIUS, 32'h7FFFFFFF);
          apb_write(REG_HEIGHT, 32'h7FFFFFFF);
          apb_write(REG_FLIP, 32'd1);
        end
        4: begin
          apb_write(REG_RADIUS, $urandom_range(32'h7FFFFFFF));
          apb_write(REG_HEIGHT, $urandom);
          apb_write(REG_FLIP, $urandom_range(1));
        end
        default: ;
      endcase
      src_idle = (ph == 0) ? 32 : (ph == 1) ? 80 : 0;
      snk_idle = (ph == 0) ? 80 : (ph == 1) ? 32 : 0;
      if (ph == 0) begin
        // parallel, plane at origin, wrong side
        add_ray(0, 0, 32'h10000, 0, 0, 0, 31'h7FFFFFFF);
        add_ray(0, 0, 0, 0, 0, -32'sh10000, 31'h7FFFFFFF);
        add_ray(0, 0, 32'h10000, 0, 0, 32'h10000, 31'h7FFFFFFF);
        // center hit, distance equal to and just under the length
        add_ray(0, 0, 32'h10000, 0, 0, -32'sh10000, 31'h20000);
        add_ray(0, 0, 32'h10000, 0, 0, -32'sh10000, 31'h10000);
        add_ray(0, 0, 32'h10000, 0, 0, -32'sh10000, 31'h10001);
        // on the rim, just outside, inside the box but outside the circle
        add_ray(32'h10000, 0, 32'h10000, 0, 0, -32'sh10000, 31'h7FFFFFFF);
        add_ray(0, -32'sh10000, 32'h10000, 0, 0, -32'sh10000, 31'h7FFFFFFF);
        add_ray(32'h10001, 0, 32'h10000, 0, 0, -32'sh10000, 31'h7FFFFFFF);
        add_ray(32'd50000, 32'd50000, 32'h10000, 0, 0, -32'sh10000, 31'h7FFFFFFF);
        // distance truncating to zero
        add_ray(0, 0, 32'd1, 0, 0, 32'h80000000, 31'h7FFFFFFF);
        // one hit per quadrant and on the negative x axis
        add_ray(32'h4000, 32'h4000, 32'h10000, 0, 0, -32'sh10000, 31'h7FFFFFFF);
        add_ray(-32'sh4000, 32'h4000, 32'h10000, 0, 0, -32'sh10000, 31'h7FFFFFFF);
        add_ray(-32'sh4000, -32'sh4000, 32'h10000, 0, 0, -32'sh10000, 31'h7FFFFFFF);
        add_ray(32'h4000, -32'sh4000, -32'sh10000, 0, 0, 32'h10000, 31'h7FFFFFFF);
        add_ray(-32'sh8000, 0, 32'h10000, 0, 0, -32'sh10000, 31'h7FFFFFFF);
        // slanted ray reaching the center
        add_ray(-32'sh10000, 32'h8000, 32'h10000, 32'h10000, -32'sh8000,
                -32'sh10000, 31'h7FFFFFFF);
        // field extremes
        add_ray(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF);
        add_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 31'h0);
        add_ray('1, '1, '1, '1, '1, '1, '1);
      end
      if (ph == 2) hold_ask++;
      for (int i = 0; i < 300; i++)
        ray_q.push_back($urandom_range(99) < 85 ? aimed_ray() : noise_ray());
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ray_disk_intersect] OK");
    end else begin
      $display("[ray_disk_intersect] ERROR");
    end
    $finish;
  end

endmodule
